// ===== rtl/ramped_pi_gate_voltage_regulator_defines.svh =====
// Assertion macros for the ramped PI gate voltage regulator.
// Used by the RTL files that carry concurrent assertions; expects clk and arst_n in scope.
`ifndef RAMPED_PI_GATE_VOLTAGE_REGULATOR_DEFINES_SVH
`define RAMPED_PI_GATE_VOLTAGE_REGULATOR_DEFINES_SVH

// same-cycle implication
`define RPGVR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rpgvr: assertion failed");

// next-cycle implication
`define RPGVR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rpgvr: assertion failed");

`endif

// ===== rtl/rpgvr_pkg.sv =====
// Shared types and constants of the ramped PI gate voltage regulator.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package rpgvr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;
	localparam int SHIFT_W = PROD_W - FRAC_BITS;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [6:0] PCT_SCALE = 7'd100;
	localparam logic [16:0] LIMIT_RESET = 17'h10000;
	localparam logic signed [31:0] SHORT_THR_RESET = 32'sh7FFF_FFFF;

	localparam logic [2:0] REG_SETPOINT = 3'd0;
	localparam logic [2:0] REG_RAMP_STEP = 3'd1;
	localparam logic [2:0] REG_PROP_GAIN = 3'd2;
	localparam logic [2:0] REG_INTEG_GAIN = 3'd3;
	localparam logic [2:0] REG_INTEG_LIMIT = 3'd4;
	localparam logic [2:0] REG_ALLOWED_PCT = 3'd5;
	localparam logic [2:0] REG_FOLLOW_LIMIT = 3'd6;
	localparam logic [2:0] REG_SHORT_THR = 3'd7;

	localparam logic [1:0] STATUS_RAMPING = 2'd0;
	localparam logic [1:0] STATUS_REACHED = 2'd1;
	localparam logic [1:0] STATUS_FOLLOW = 2'd2;
	localparam logic [1:0] STATUS_SHORT = 2'd3;

	typedef struct packed {
		logic [30:0] setpoint;
		logic [30:0] ramp_step;
		logic signed [31:0] prop_gain;
		logic signed [31:0] integ_gain;
		logic [30:0] integ_limit;
		logic [30:0] allowed_pct;
		logic [16:0] follow_limit;
		logic signed [31:0] short_thr;
	} cfg_t;

	typedef struct packed {
		logic [30:0] ref_v;
		logic signed [31:0] integ;
		logic [15:0] count;
		logic seen;
	} st_t;

	typedef struct packed {
		logic restart;
		logic signed [31:0] voltage;
		logic signed [31:0] current;
	} item_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic signed [31:0] err;
		logic [1:0] status;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/rpgvr_regs.sv =====
// APB configuration registers of the ramped PI gate voltage regulator.
// Depends on rpgvr_pkg for the register map and the configuration struct.
`default_nettype none

module rpgvr_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output rpgvr_pkg::cfg_t cfg
);

	rpgvr_pkg::cfg_t cfg_q;
	logic wr_en;
	logic [2:0] idx;

	assign idx = paddr[4:2];
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint <= '0;
			cfg_q.ramp_step <= '0;
			cfg_q.prop_gain <= '0;
			cfg_q.integ_gain <= '0;
			cfg_q.integ_limit <= '0;
			cfg_q.allowed_pct <= '0;
			cfg_q.follow_limit <= rpgvr_pkg::LIMIT_RESET;
			cfg_q.short_thr <= rpgvr_pkg::SHORT_THR_RESET;
		end else if (wr_en) begin
			unique case (idx)
				rpgvr_pkg::REG_SETPOINT: cfg_q.setpoint <= pwdata[30:0];
				rpgvr_pkg::REG_RAMP_STEP: cfg_q.ramp_step <= pwdata[30:0];
				rpgvr_pkg::REG_PROP_GAIN: cfg_q.prop_gain <= pwdata;
				rpgvr_pkg::REG_INTEG_GAIN: cfg_q.integ_gain <= pwdata;
				rpgvr_pkg::REG_INTEG_LIMIT: cfg_q.integ_limit <= pwdata[30:0];
				rpgvr_pkg::REG_ALLOWED_PCT: cfg_q.allowed_pct <= pwdata[30:0];
				rpgvr_pkg::REG_FOLLOW_LIMIT: cfg_q.follow_limit <= pwdata[16:0];
				rpgvr_pkg::REG_SHORT_THR: cfg_q.short_thr <= pwdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			rpgvr_pkg::REG_SETPOINT: prdata = {1'b0, cfg_q.setpoint};
			rpgvr_pkg::REG_RAMP_STEP: prdata = {1'b0, cfg_q.ramp_step};
			rpgvr_pkg::REG_PROP_GAIN: prdata = cfg_q.prop_gain;
			rpgvr_pkg::REG_INTEG_GAIN: prdata = cfg_q.integ_gain;
			rpgvr_pkg::REG_INTEG_LIMIT: prdata = {1'b0, cfg_q.integ_limit};
			rpgvr_pkg::REG_ALLOWED_PCT: prdata = {1'b0, cfg_q.allowed_pct};
			rpgvr_pkg::REG_FOLLOW_LIMIT: prdata = {15'd0, cfg_q.follow_limit};
			rpgvr_pkg::REG_SHORT_THR: prdata = cfg_q.short_thr;
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/rpgvr_core.sv =====
// One-sample datapath: ramp, tracking error, relative check, counter and PI law.
// Depends on rpgvr_pkg; purely combinational between the top level's registers.
`default_nettype none

module rpgvr_core (
	input rpgvr_pkg::cfg_t cfg,
	input rpgvr_pkg::st_t st,
	input rpgvr_pkg::item_t item,
	output rpgvr_pkg::st_t st_next,
	output rpgvr_pkg::res_t res
);

	localparam int SW = rpgvr_pkg::SHIFT_W;
	localparam int PW = rpgvr_pkg::PROD_W;
	localparam int FB = rpgvr_pkg::FRAC_BITS;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -64'sh0000_0000_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	logic [30:0] ref0, ref1;
	logic [31:0] ref_sum;
	logic seen0;
	logic signed [31:0] int0, int1, err, ki, kp, vs, cs, thr, ref_s, lim, neg_lim;
	logic signed [32:0] diff, err33, abs33;
	logic [31:0] abs_err;
	logic [63:0] lhs;
	logic [61:0] rhs;
	logic pass;
	logic [15:0] cnt0, cnt1;
	logic [1:0] status;
	logic signed [PW-1:0] prod_i, prod_p;
	logic signed [SW-1:0] inc_i, qp;
	logic signed [SW:0] int_sum;
	logic signed [SW+1:0] drive_sum;

	assign ki = cfg.integ_gain;
	assign kp = cfg.prop_gain;
	assign thr = cfg.short_thr;
	assign vs = item.voltage;
	assign cs = item.current;

	assign ref0 = item.restart ? '0 : st.ref_v;
	assign seen0 = item.restart ? 1'b0 : st.seen;
	assign int0 = seen0 ? st.integ : '0;
	assign cnt0 = item.restart ? '0 : st.count;

	assign ref_sum = {1'b0, ref0} + {1'b0, cfg.ramp_step};

	always_comb begin
		if (ref0 < cfg.setpoint) begin
			ref1 = ref_sum[31] ? 31'h7FFF_FFFF : ref_sum[30:0];
			status = rpgvr_pkg::STATUS_RAMPING;
		end else begin
			ref1 = cfg.setpoint;
			status = rpgvr_pkg::STATUS_REACHED;
		end
		ref_s = signed'({1'b0, ref1});
		diff = 33'(ref_s) - 33'(vs);
		err = seen0 ? sat32(64'(diff)) : '0;

		err33 = 33'(err);
		abs33 = err[31] ? -err33 : err33;
		abs_err = abs33[31:0];
		lhs = (64'(abs_err) * 64'(rpgvr_pkg::PCT_SCALE)) << FB;
		rhs = cfg.allowed_pct * ref1;
		pass = lhs < 64'(rhs);

		if (pass)
			cnt1 = (cnt0 != '0) ? cnt0 - 16'd1 : cnt0;
		else begin
			cnt1 = (cnt0 != rpgvr_pkg::COUNT_MAX) ? cnt0 + 16'd1 : cnt0;
			if (cs >= thr)
				status = rpgvr_pkg::STATUS_SHORT;
			else if (!cfg.follow_limit[16] && ({1'b0, cnt1} >= cfg.follow_limit))
				status = rpgvr_pkg::STATUS_FOLLOW;
		end

		prod_i = PW'(err) * PW'(ki);
		prod_p = PW'(err) * PW'(kp);
		inc_i = prod_i[PW-1:FB];
		qp = prod_p[PW-1:FB];

		lim = signed'({1'b0, cfg.integ_limit});
		neg_lim = -lim;
		int_sum = (SW+1)'(int0) + (SW+1)'(inc_i);
		if (int_sum > (SW+1)'(lim))
			int1 = lim;
		else if (int_sum < (SW+1)'(neg_lim))
			int1 = neg_lim;
		else
			int1 = int_sum[31:0];

		drive_sum = (SW+2)'(ref_s) + (SW+2)'(qp) + (SW+2)'(int1);
	end

	assign st_next.ref_v = ref1;
	assign st_next.integ = int1;
	assign st_next.count = cnt1;
	assign st_next.seen = 1'b1;

	assign res.drive = sat32(64'(drive_sum));
	assign res.err = err;
	assign res.status = status;

endmodule

`default_nettype wire

// ===== rtl/ramped_pi_gate_voltage_regulator.sv =====
// Ramped PI gate voltage regulator, top level.
// Depends on rpgvr_pkg, rpgvr_regs, rpgvr_core and the assertion macro header.
// Configuration: APB port, register i at byte address 4*i, pready always high.
// Sample requests enter on s_tvalid/s_tready/s_tdata/s_tuser; results leave on
// m_tvalid/m_tready/m_tdata/m_tuser, one result per sample, in order.
// A request is held in the input register; the core then computes the
// ramp, error, check and PI law in one pass into the result register, so
// m_tvalid rises once the result register is loaded. Throughput is one request
// per cycle without a stall, set by the single-pass core that closes the state
// loop. When the receiver stalls, the result register holds and the input
// register takes one more request; then s_tready drops until m_tready returns.
// Reset clears the ramp, integral, counter and first-sample flag and loads the
// register reset values; no request is lost or repeated across stalls.
`default_nettype none
`include "ramped_pi_gate_voltage_regulator_defines.svh"

module ramped_pi_gate_voltage_regulator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [63:0] s_tdata, // [31:0] voltage_sample, [63:32] current_sample
	input wire logic [0:0] s_tuser, // [0] restart
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [63:0] m_tdata, // [31:0] drive_voltage, [63:32] tracking_error
	output logic [1:0] m_tuser // [1:0] status
);

	rpgvr_pkg::cfg_t cfg;
	rpgvr_pkg::st_t st_q, st_next;
	rpgvr_pkg::item_t item_s1;
	rpgvr_pkg::res_t res, res_q;
	logic v_s1, out_valid_q, adv;

	assign pready = 1'b1;

	rpgvr_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.cfg(cfg)
	);

	rpgvr_core u_core (
		.cfg(cfg),
		.st(st_q),
		.item(item_s1),
		.st_next(st_next),
		.res(res)
	);

	assign adv = !out_valid_q || m_tready;
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.restart <= s_tuser[0];
			item_s1.voltage <= s_tdata[31:0];
			item_s1.current <= s_tdata[63:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			st_q <= '0;
		end else if (adv) begin
			out_valid_q <= v_s1;
			if (v_s1)
				st_q <= st_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {res_q.err, res_q.drive};
	assign m_tuser = res_q.status;

	`RPGVR_ASSERT_NEXT(a_restart_zero_err, v_s1 && adv && item_s1.restart, m_tdata[63:32] == '0)
	`RPGVR_ASSERT_NEXT(a_done_sets_seen, v_s1 && adv, m_tvalid && st_q.seen)
	`RPGVR_ASSERT_NEXT(a_hold_pending, v_s1 && !adv, v_s1)
	`RPGVR_ASSERT_IMPL(a_follow_count, m_tvalid && (m_tuser == rpgvr_pkg::STATUS_FOLLOW), st_q.count != '0)

endmodule

`default_nettype wire
